@@ rtl/mstt_pkg.sv @@
// shared constants, codes and payload types for the one-shot task timer
`default_nettype none

package mstt_pkg;

    localparam int SLOTS = 8;
    localparam int MAX_OUT = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;
    localparam logic [1:0] CMD_COLLECT  = 2'd3;

    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_READY     = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  slot;
        logic [15:0] task_id;
        logic [15:0] duration;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_out;
        logic [15:0] task_out;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] duration;
        logic [15:0] elapsed;
    } row_t;

endpackage

`default_nettype wire

@@ rtl/multi_slot_oneshot_task_timer.sv @@
// one-shot task timer slot table walked by one shared update unit
// schedule: out-of-range slots are rejected; if the target is active a cancel walk runs first
// tick and cancel: one slot read per cycle from the slot memory
// collect: a single NONE result with nothing ready, else one result per ready slot reached
// results are one-cycle registered strobes that cannot be stalled; next request once busy drops
// reset stops the timer and marks every slot unwritten, so all slots read as zero
`default_nettype none

module multi_slot_oneshot_task_timer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mstt_pkg::req_t  request,
    output logic                 strobe,
    output mstt_pkg::res_t       result
);

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_SCHED_CHK = 2'd1;
    localparam logic [1:0] S_WALK      = 2'd2;
    localparam logic [1:0] S_SCHED_WR  = 2'd3;

    localparam int IW = mstt_pkg::IDX_W;
    localparam int CW = mstt_pkg::CNT_W;
    localparam int OW = mstt_pkg::OUT_CNT_W;
    localparam int NS = mstt_pkg::SLOTS;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [15:0]          id_reg, id_next;
    logic [15:0]          dur_reg, dur_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 pv_reg, pv_next;
    logic [IW-1:0]        pidx_reg, pidx_next;
    logic                 any_reg, any_next;
    logic [OW-1:0]        n_reg, n_next;
    logic                 running_reg, running_next;
    logic [NS-1:0]        ready_reg, ready_next;
    logic [NS-1:0]        vld_reg;
    logic                 strobe_reg, strobe_next;
    mstt_pkg::res_t       res_reg, res_next;

    mstt_pkg::row_t       mem [NS];
    mstt_pkg::row_t       row_reg;
    logic                 rd_vld_reg;
    mstt_pkg::row_t       row;
    mstt_pkg::row_t       wr_row;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [IW-1:0]        rd_addr;

    logic [15:0]          elapsed_inc;
    logic                 expire;
    logic                 walk_end;
    logic                 id_match;
    logic [NS-1:0]        ready_above;
    logic                 last_ready;

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    // unwritten slots read as zero
    assign row         = rd_vld_reg ? row_reg : '0;
    assign elapsed_inc = row.elapsed + 16'd1;
    assign expire      = (elapsed_inc >= row.duration);
    assign walk_end    = pv_reg && (pidx_reg == IW'(NS - 1));
    assign id_match    = (row.task_id == id_reg);

    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            ready_above[j] = ready_reg[j] && (IW'(j) > pidx_reg);
        end
    end

    assign last_ready = (n_reg == OW'(mstt_pkg::MAX_OUT - 1)) || (ready_above == '0);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        dur_next     = dur_reg;
        slot_next    = slot_reg;
        rd_cnt_next  = rd_cnt_reg;
        pv_next      = pv_reg;
        pidx_next    = pidx_reg;
        any_next     = any_reg;
        n_next       = n_reg;
        running_next = running_reg;
        ready_next   = ready_reg;
        strobe_next  = 1'b0;
        res_next     = '0;
        wr_en        = 1'b0;
        wr_addr      = pidx_reg;
        wr_row       = row;
        rd_addr      = rd_cnt_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = request.slot[IW-1:0];
                if (start)
                begin
                    cmd_next    = request.cmd;
                    id_next     = request.task_id;
                    dur_next    = request.duration;
                    slot_next   = request.slot[IW-1:0];
                    rd_cnt_next = '0;
                    pv_next     = 1'b0;
                    any_next    = 1'b0;
                    n_next      = '0;
                    unique case (request.cmd)
                        mstt_pkg::CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        mstt_pkg::CMD_SCHEDULE:
                        begin
                            if (request.slot >= 8'(NS))
                            begin
                                strobe_next       = 1'b1;
                                res_next.status   = mstt_pkg::ST_REJECTED;
                                res_next.slot_out = request.slot;
                                res_next.last     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCHED_CHK;
                            end
                        end
                        mstt_pkg::CMD_CANCEL:
                        begin
                            state_next = S_WALK;
                        end
                        mstt_pkg::CMD_COLLECT:
                        begin
                            if (ready_reg == '0)
                            begin
                                strobe_next     = 1'b1;
                                res_next.status = mstt_pkg::ST_NONE;
                                res_next.last   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCHED_CHK:
            begin
                // active target: cancel the first slot holding this id first
                if (row.duration != 16'd0)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_SCHED_WR;
                end
            end

            S_WALK:
            begin
                if (rd_cnt_reg != CW'(NS))
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                    pv_next     = 1'b1;
                    pidx_next   = rd_cnt_reg[IW-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end

                if (pv_reg)
                begin
                    unique case (cmd_reg) inside
                        mstt_pkg::CMD_TICK:
                        begin
                            if (row.duration != 16'd0)
                            begin
                                any_next       = 1'b1;
                                wr_en          = 1'b1;
                                wr_row.elapsed = elapsed_inc;
                                if (expire)
                                begin
                                    wr_row.duration      = 16'd0;
                                    ready_next[pidx_reg] = 1'b1;
                                end
                            end
                            if (walk_end)
                            begin
                                running_next = any_reg || (row.duration != 16'd0);
                                state_next   = S_IDLE;
                            end
                        end
                        mstt_pkg::CMD_SCHEDULE, mstt_pkg::CMD_CANCEL:
                        begin
                            if (id_match)
                            begin
                                wr_en                = 1'b1;
                                wr_row.duration      = 16'd0;
                                ready_next[pidx_reg] = 1'b0;
                            end
                            if (id_match || walk_end)
                            begin
                                if (cmd_reg == mstt_pkg::CMD_CANCEL)
                                begin
                                    strobe_next     = 1'b1;
                                    res_next.status = id_match ? mstt_pkg::ST_CANCELLED
                                                               : mstt_pkg::ST_NOT_FOUND;
                                    res_next.last   = 1'b1;
                                    state_next      = S_IDLE;
                                end
                                else
                                begin
                                    state_next = S_SCHED_WR;
                                end
                            end
                        end
                        mstt_pkg::CMD_COLLECT:
                        begin
                            if (ready_reg[pidx_reg])
                            begin
                                strobe_next          = 1'b1;
                                res_next.status      = mstt_pkg::ST_READY;
                                res_next.slot_out    = 8'(pidx_reg);
                                res_next.task_out    = row.task_id;
                                res_next.last        = last_ready;
                                wr_en                = 1'b1;
                                wr_row.duration      = 16'd0;
                                wr_row.elapsed       = 16'd0;
                                ready_next[pidx_reg] = 1'b0;
                                n_next               = n_reg + OW'(1);
                                if (last_ready)
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                            if (walk_end)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCHED_WR:
            begin
                wr_en             = 1'b1;
                wr_addr           = slot_reg;
                wr_row.task_id    = id_reg;
                wr_row.duration   = dur_reg;
                wr_row.elapsed    = 16'd0;
                running_next      = 1'b1;
                strobe_next       = 1'b1;
                res_next.status   = mstt_pkg::ST_SCHEDULED;
                res_next.slot_out = 8'(slot_reg);
                res_next.last     = 1'b1;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= mstt_pkg::CMD_TICK;
            rd_cnt_reg  <= '0;
            pv_reg      <= 1'b0;
            pidx_reg    <= '0;
            any_reg     <= 1'b0;
            n_reg       <= '0;
            running_reg <= 1'b0;
            ready_reg   <= '0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            rd_cnt_reg  <= rd_cnt_next;
            pv_reg      <= pv_next;
            pidx_reg    <= pidx_next;
            any_reg     <= any_next;
            n_reg       <= n_next;
            running_reg <= running_next;
            ready_reg   <= ready_next;
            rd_vld_reg  <= vld_reg[rd_addr];
            strobe_reg  <= strobe_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        dur_reg  <= dur_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        row_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("final result shown while a command is still running");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != mstt_pkg::ST_READY |-> result.last)
        else $error("single-result command without last");

    a_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != mstt_pkg::ST_READY |-> result.task_out == 16'd0)
        else $error("task id on a result that carries none");

    a_collect_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= OW'(mstt_pkg::MAX_OUT))
        else $error("collect reported more slots than allowed");

    a_sched_runs: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == mstt_pkg::ST_SCHEDULED |-> running_reg)
        else $error("timer not running after schedule");
`endif

endmodule

`default_nettype wire
